>>> rtl/msde_pkg.sv
// shared types, opcodes and pipeline structs for the mips subset decode/execute core
package msde_pkg;

    localparam logic [5:0] OPC_SPECIAL = 6'd0;
    localparam logic [5:0] OPC_J       = 6'd2;
    localparam logic [5:0] OPC_JAL     = 6'd3;
    localparam logic [5:0] OPC_BEQ     = 6'd4;
    localparam logic [5:0] OPC_ADDIU   = 6'd9;
    localparam logic [5:0] OPC_ORI     = 6'd13;
    localparam logic [5:0] OPC_LUI     = 6'd15;
    localparam logic [5:0] OPC_LW      = 6'd35;
    localparam logic [5:0] OPC_SW      = 6'd43;

    localparam logic [5:0] FN_NOP  = 6'd0;
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_JALR = 6'd9;
    localparam logic [5:0] FN_ADD  = 6'd32;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_OR   = 6'd37;

    localparam logic [4:0] LINK_REG = 5'd31;
    localparam logic [31:0] INSN_BYTES = 32'd4;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ADD,
        OP_OR,
        OP_JR,
        OP_JALR,
        OP_J,
        OP_JAL,
        OP_BEQ,
        OP_ADDIU,
        OP_ORI,
        OP_LUI,
        OP_LW,
        OP_SW,
        OP_ILLEGAL
    } op_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc_value;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
    } in_item_t;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [31:0] write_value;
        logic        branch_taken;
        logic [31:0] branch_target;
        logic [1:0]  mem_op;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        illegal;
    } out_item_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  dest;
        logic [15:0] imm;
        logic [25:0] jidx;
        logic [31:0] pc;
        logic [31:0] link;
        logic [31:0] rs;
        logic [31:0] rt;
    } dec_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  dest;
        logic [15:0] imm;
        logic [31:0] sum;
        logic [31:0] or_val;
        logic [31:0] link;
        logic [31:0] br_tgt;
        logic [31:0] jump_tgt;
        logic        eq;
        logic [31:0] rs;
        logic [31:0] rt;
    } exec_t;

endpackage

>>> rtl/msde_decode.sv
// stage 1: opcode/funct decode, destination select and link address
module msde_decode
    import msde_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output dec_t     out_data
);

    logic       valid_reg;
    dec_t       data_reg;
    dec_t       data_next;
    logic [5:0] opc;
    logic [5:0] fn;

    assign opc = in_data.instruction[31:26];
    assign fn  = in_data.instruction[5:0];

    always_comb
    begin
        data_next      = '0;
        data_next.op   = OP_ILLEGAL;
        data_next.imm  = in_data.instruction[15:0];
        data_next.jidx = in_data.instruction[25:0];
        data_next.pc   = in_data.pc_value;
        data_next.link = in_data.pc_value + INSN_BYTES;
        data_next.rs   = in_data.rs_value;
        data_next.rt   = in_data.rt_value;
        unique case (opc)
            OPC_SPECIAL:
            begin
                data_next.dest = in_data.instruction[15:11];
                unique case (fn)
                    FN_NOP:  data_next.op = OP_NOP;
                    FN_ADD:  data_next.op = OP_ADD;
                    FN_ADDU: data_next.op = OP_ADD;
                    FN_OR:   data_next.op = OP_OR;
                    FN_JR:   data_next.op = OP_JR;
                    FN_JALR: data_next.op = OP_JALR;
                    default: data_next.op = OP_ILLEGAL;
                endcase
            end
            OPC_J:
            begin
                data_next.op = OP_J;
            end
            OPC_JAL:
            begin
                data_next.op   = OP_JAL;
                data_next.dest = LINK_REG;
            end
            OPC_BEQ:
            begin
                data_next.op = OP_BEQ;
            end
            OPC_ADDIU:
            begin
                data_next.op   = OP_ADDIU;
                data_next.dest = in_data.instruction[20:16];
            end
            OPC_ORI:
            begin
                data_next.op   = OP_ORI;
                data_next.dest = in_data.instruction[20:16];
            end
            OPC_LUI:
            begin
                data_next.op   = OP_LUI;
                data_next.dest = in_data.instruction[20:16];
            end
            OPC_LW:
            begin
                data_next.op   = OP_LW;
                data_next.dest = in_data.instruction[20:16];
            end
            OPC_SW:
            begin
                data_next.op = OP_SW;
            end
            default:
            begin
                data_next.op = OP_ILLEGAL;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/msde_execute.sv
// stage 2: alu add/or, branch target add, jump target and compare
module msde_execute
    import msde_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  dec_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output exec_t out_data
);

    logic        valid_reg;
    exec_t       data_reg;
    exec_t       data_next;
    logic [31:0] imm_sext;
    logic [31:0] operand_b;

    assign imm_sext = {{16{in_data.imm[15]}}, in_data.imm};

    always_comb
    begin
        unique case (in_data.op)
            OP_ADD, OP_OR: operand_b = in_data.rt;
            OP_ORI:        operand_b = {16'h0000, in_data.imm};
            default:       operand_b = imm_sext;
        endcase
    end

    always_comb
    begin
        data_next          = '0;
        data_next.op       = in_data.op;
        data_next.dest     = in_data.dest;
        data_next.imm      = in_data.imm;
        data_next.sum      = in_data.rs + operand_b;
        data_next.or_val   = in_data.rs | operand_b;
        data_next.link     = in_data.link;
        data_next.br_tgt   = in_data.link + {imm_sext[29:0], 2'b00};
        data_next.jump_tgt = {in_data.pc[31:28], in_data.jidx, 2'b00};
        data_next.eq       = (in_data.rs == in_data.rt);
        data_next.rs       = in_data.rs;
        data_next.rt       = in_data.rt;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/msde_format.sv
// stage 3: per-instruction result select into the output register
module msde_format
    import msde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  exec_t     in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      valid_reg;
    out_item_t data_reg;
    out_item_t data_next;

    always_comb
    begin
        data_next = '0;
        unique case (in_data.op)
            OP_NOP:
            begin
                data_next = '0;
            end
            OP_ADD, OP_ADDIU:
            begin
                data_next.write_enable = 1'b1;
                data_next.dest_index   = in_data.dest;
                data_next.write_value  = in_data.sum;
            end
            OP_OR, OP_ORI:
            begin
                data_next.write_enable = 1'b1;
                data_next.dest_index   = in_data.dest;
                data_next.write_value  = in_data.or_val;
            end
            OP_JR:
            begin
                data_next.branch_taken  = 1'b1;
                data_next.branch_target = in_data.rs;
            end
            OP_JALR:
            begin
                data_next.write_enable  = 1'b1;
                data_next.dest_index    = in_data.dest;
                data_next.write_value   = in_data.link;
                data_next.branch_taken  = 1'b1;
                data_next.branch_target = in_data.rs;
            end
            OP_J:
            begin
                data_next.branch_taken  = 1'b1;
                data_next.branch_target = in_data.jump_tgt;
            end
            OP_JAL:
            begin
                data_next.write_enable  = 1'b1;
                data_next.dest_index    = in_data.dest;
                data_next.write_value   = in_data.link;
                data_next.branch_taken  = 1'b1;
                data_next.branch_target = in_data.jump_tgt;
            end
            OP_BEQ:
            begin
                data_next.branch_taken  = in_data.eq;
                data_next.branch_target = in_data.br_tgt;
            end
            OP_LUI:
            begin
                data_next.write_enable = 1'b1;
                data_next.dest_index   = in_data.dest;
                data_next.write_value  = {in_data.imm, 16'h0000};
            end
            OP_LW:
            begin
                data_next.write_enable = 1'b1;
                data_next.dest_index   = in_data.dest;
                data_next.mem_op       = MEM_LOAD;
                data_next.mem_address  = in_data.sum;
            end
            OP_SW:
            begin
                data_next.mem_op      = MEM_STORE;
                data_next.mem_address = in_data.sum;
                data_next.store_data  = in_data.rt;
            end
            default:
            begin
                data_next.illegal = 1'b1;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/mips_subset_decode_execute_core.sv
// Decode/execute core for a MIPS32 integer subset (NOP, ADD, ADDU, OR, JR, JALR, J, JAL,
// BEQ, ADDIU, ORI, LUI, LW, SW). One instruction transaction in gives exactly one result
// transaction out, in order. The core is a three-stage pipeline (decode, execute adders,
// result select) with valid/ready on both sides: it takes one instruction every clock
// while the output is not stalled, and each result is registered through the decode,
// execute and result-select stage registers in turn. A stall at the output backs up
// through the stage registers without dropping or repeating anything. LW reports
// write_enable with write_value 0; the loaded word is written back elsewhere. Unsupported
// encodings give illegal with all else zero.
module mips_subset_decode_execute_core
    import msde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic  dec_valid;
    logic  dec_ready;
    dec_t  dec_data;
    logic  exe_valid;
    logic  exe_ready;
    exec_t exe_data;

    msde_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    msde_execute u_execute (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (exe_valid),
        .out_ready (exe_ready),
        .out_data  (exe_data)
    );

    msde_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (exe_valid),
        .in_ready  (exe_ready),
        .in_data   (exe_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // illegal results carry nothing else
    a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.illegal |->
            !out_data.write_enable && !out_data.branch_taken
            && out_data.mem_op == MEM_NONE && out_data.write_value == '0)
        else $error("illegal result with nonzero fields");

    // store never writes a register and never branches
    a_store_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mem_op == MEM_STORE |->
            !out_data.write_enable && !out_data.branch_taken)
        else $error("store result with writeback or branch");

    // load writes back zero, never branches
    a_load_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mem_op == MEM_LOAD |->
            out_data.write_enable && out_data.write_value == '0 && !out_data.branch_taken)
        else $error("load result malformed");

    // a stage that holds a transaction while the output is free keeps the pipe moving
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalled with output ready");

endmodule

>>> tb/sv/insn_result_checker.sv
// checker for the decode/execute core: predicts each result and compares it in order
module insn_result_checker
    import msde_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        mismatch_count,
    output int        results_due
);

    typedef struct {
        logic [31:0] instruction;
        out_item_t   result;
    } due_t;

    due_t expected_results[$];

    function automatic out_item_t execute_insn(in_item_t t);
        logic [5:0]  opc;
        logic [5:0]  fn;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [15:0] imm;
        logic [31:0] imm_sx;
        logic [31:0] jump_tgt;
        out_item_t   r;
        opc      = t.instruction[31:26];
        rt       = t.instruction[20:16];
        rd       = t.instruction[15:11];
        fn       = t.instruction[5:0];
        imm      = t.instruction[15:0];
        imm_sx   = {{16{imm[15]}}, imm};
        jump_tgt = {t.pc_value[31:28], t.instruction[25:0], 2'b00};
        r        = '0;
        case (opc)
            OPC_SPECIAL:
                case (fn)
                    FN_NOP:
                        r = '0;
                    FN_ADD, FN_ADDU:
                    begin
                        r.write_enable = 1'b1;
                        r.dest_index   = rd;
                        r.write_value  = t.rs_value + t.rt_value;
                    end
                    FN_OR:
                    begin
                        r.write_enable = 1'b1;
                        r.dest_index   = rd;
                        r.write_value  = t.rs_value | t.rt_value;
                    end
                    FN_JR:
                    begin
                        r.branch_taken  = 1'b1;
                        r.branch_target = t.rs_value;
                    end
                    FN_JALR:
                    begin
                        r.write_enable  = 1'b1;
                        r.dest_index    = rd;
                        r.write_value   = t.pc_value + INSN_BYTES;
                        r.branch_taken  = 1'b1;
                        r.branch_target = t.rs_value;
                    end
                    default:
                        r.illegal = 1'b1;
                endcase
            OPC_J:
            begin
                r.branch_taken  = 1'b1;
                r.branch_target = jump_tgt;
            end
            OPC_JAL:
            begin
                r.write_enable  = 1'b1;
                r.dest_index    = LINK_REG;
                r.write_value   = t.pc_value + INSN_BYTES;
                r.branch_taken  = 1'b1;
                r.branch_target = jump_tgt;
            end
            OPC_BEQ:
            begin
                r.branch_taken  = (t.rs_value == t.rt_value);
                r.branch_target = t.pc_value + INSN_BYTES + {imm_sx[29:0], 2'b00};
            end
            OPC_ADDIU:
            begin
                r.write_enable = 1'b1;
                r.dest_index   = rt;
                r.write_value  = t.rs_value + imm_sx;
            end
            OPC_ORI:
            begin
                r.write_enable = 1'b1;
                r.dest_index   = rt;
                r.write_value  = t.rs_value | {16'h0000, imm};
            end
            OPC_LUI:
            begin
                r.write_enable = 1'b1;
                r.dest_index   = rt;
                r.write_value  = {imm, 16'h0000};
            end
            OPC_LW:
            begin
                r.write_enable = 1'b1;
                r.dest_index   = rt;
                r.mem_op       = MEM_LOAD;
                r.mem_address  = t.rs_value + imm_sx;
            end
            OPC_SW:
            begin
                r.mem_op      = MEM_STORE;
                r.mem_address = t.rs_value + imm_sx;
                r.store_data  = t.rt_value;
            end
            default:
                r.illegal = 1'b1;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count = mismatch_count + 1;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        due_t head;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back('{in_data.instruction, execute_insn(in_data)});
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with no transaction pending: %h",
                                              out_data));
                else
                begin
                    head = expected_results.pop_front();
                    if (out_data.write_enable !== head.result.write_enable)
                        report_mismatch($sformatf("insn %h write_enable got %b expected %b",
                            head.instruction, out_data.write_enable,
                            head.result.write_enable));
                    if (out_data.dest_index !== head.result.dest_index)
                        report_mismatch($sformatf("insn %h dest_index got %0d expected %0d",
                            head.instruction, out_data.dest_index, head.result.dest_index));
                    if (out_data.write_value !== head.result.write_value)
                        report_mismatch($sformatf("insn %h write_value got %h expected %h",
                            head.instruction, out_data.write_value,
                            head.result.write_value));
                    if (out_data.branch_taken !== head.result.branch_taken)
                        report_mismatch($sformatf("insn %h branch_taken got %b expected %b",
                            head.instruction, out_data.branch_taken,
                            head.result.branch_taken));
                    if (out_data.branch_target !== head.result.branch_target)
                        report_mismatch($sformatf("insn %h branch_target got %h expected %h",
                            head.instruction, out_data.branch_target,
                            head.result.branch_target));
                    if (out_data.mem_op !== head.result.mem_op)
                        report_mismatch($sformatf("insn %h mem_op got %0d expected %0d",
                            head.instruction, out_data.mem_op, head.result.mem_op));
                    if (out_data.mem_address !== head.result.mem_address)
                        report_mismatch($sformatf("insn %h mem_address got %h expected %h",
                            head.instruction, out_data.mem_address,
                            head.result.mem_address));
                    if (out_data.store_data !== head.result.store_data)
                        report_mismatch($sformatf("insn %h store_data got %h expected %h",
                            head.instruction, out_data.store_data,
                            head.result.store_data));
                    if (out_data.illegal !== head.result.illegal)
                        report_mismatch($sformatf("insn %h illegal got %b expected %b",
                            head.instruction, out_data.illegal, head.result.illegal));
                end
            end
        end
        results_due <= expected_results.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// top-level bench for the decode/execute core: clock, reset, stimulus, flow control and verdict
module tb_top
    import msde_pkg::*;
();

    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_ITEMS  = 188;
    localparam int DRAIN_CYCLES = 8;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    int mismatch_count;
    int results_due;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_cycles   = 0;

    int phase_send_idle[4] = '{0, 62, 0, 36};
    int phase_stall[4]     = '{0, 0, 62, 36};

    mips_subset_decode_execute_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    insn_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .mismatch_count(mismatch_count),
        .results_due   (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sh, logic [5:0] fn);
        return {OPC_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic logic [31:0] j_word(logic [5:0] opc, logic [25:0] idx);
        return {opc, idx};
    endfunction

    // biased toward values that hit carries and sign boundaries
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic in_item_t random_insn();
        op_t         op;
        int          pick;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [15:0] imm;
        logic [31:0] insn;
        in_item_t    item;
        pick = $urandom_range(0, 15);
        op   = (pick >= OP_ILLEGAL) ? OP_ILLEGAL : op_t'(pick);
        rs   = 5'($urandom());
        rt   = 5'($urandom());
        rd   = 5'($urandom());
        sh   = 5'($urandom());
        imm  = 16'($urandom());
        case (op)
            OP_NOP:   insn = r_word(rs, rt, rd, sh, FN_NOP);
            OP_ADD:   insn = r_word(rs, rt, rd, sh, $urandom_range(0, 1) ? FN_ADD : FN_ADDU);
            OP_OR:    insn = r_word(rs, rt, rd, sh, FN_OR);
            OP_JR:    insn = r_word(rs, rt, rd, sh, FN_JR);
            OP_JALR:  insn = r_word(rs, rt, rd, sh, FN_JALR);
            OP_J:     insn = j_word(OPC_J, 26'($urandom()));
            OP_JAL:   insn = j_word(OPC_JAL, 26'($urandom()));
            OP_BEQ:   insn = i_word(OPC_BEQ, rs, rt, imm);
            OP_ADDIU: insn = i_word(OPC_ADDIU, rs, rt, imm);
            OP_ORI:   insn = i_word(OPC_ORI, rs, rt, imm);
            OP_LUI:   insn = i_word(OPC_LUI, rs, rt, imm);
            OP_LW:    insn = i_word(OPC_LW, rs, rt, imm);
            OP_SW:    insn = i_word(OPC_SW, rs, rt, imm);
            default:  insn = $urandom_range(0, 1) ? $urandom()
                                                  : r_word(rs, rt, rd, sh, 6'($urandom()));
        endcase
        item = '{insn, rand_word(), rand_word(), rand_word()};
        if (op == OP_BEQ && $urandom_range(0, 1))
            item.rt_value = item.rs_value;
        return item;
    endfunction

    task automatic send_insn(in_item_t item);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every operation, field extremes and the corner cases
        send_insn('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_insn('{r_word(5'h1F, 5'h1F, 5'h1F, 5'h1F, FN_NOP),
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_insn('{r_word(5'd1, 5'd2, 5'd31, 5'd0, FN_ADD),
                    32'h0000_1000, 32'h7FFF_FFFF, 32'h0000_0001});
        send_insn('{r_word(5'd3, 5'd4, 5'd0, 5'd0, FN_ADD),
                    32'h0000_1004, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_insn('{r_word(5'd5, 5'd6, 5'd7, 5'h15, FN_ADDU),
                    32'h0000_1008, 32'h8000_0000, 32'h8000_0000});
        send_insn('{r_word(5'd8, 5'd9, 5'd10, 5'd0, FN_OR),
                    32'h0000_100C, 32'hF0F0_F0F0, 32'h0F0F_0F0F});
        send_insn('{r_word(5'd11, 5'h1F, 5'h1F, 5'h1F, FN_JR),
                    32'h0000_1010, 32'hFFFF_FFFC, 32'h1234_5678});
        send_insn('{r_word(5'd12, 5'd0, 5'd31, 5'd0, FN_JALR),
                    32'hFFFF_FFFC, 32'h0040_0000, 32'h0000_0000});
        send_insn('{j_word(OPC_J, 26'h3FF_FFFF), 32'hFFFF_FFFF, 32'h0, 32'h0});
        send_insn('{j_word(OPC_JAL, 26'h000_0000), 32'h8000_0000, 32'h0, 32'h0});
        send_insn('{i_word(OPC_BEQ, 5'd1, 5'd1, 16'h8000),
                    32'h0000_0000, 32'hDEAD_BEEF, 32'hDEAD_BEEF});
        send_insn('{i_word(OPC_BEQ, 5'd1, 5'd2, 16'h7FFF),
                    32'hFFFF_FFF0, 32'h0000_0001, 32'h0000_0002});
        send_insn('{i_word(OPC_ADDIU, 5'd1, 5'd2, 16'hFFFF),
                    32'h0000_2000, 32'h0000_0000, 32'h0});
        send_insn('{i_word(OPC_ADDIU, 5'd1, 5'd0, 16'h7FFF),
                    32'h0000_2004, 32'h7FFF_FFFF, 32'h0});
        send_insn('{i_word(OPC_ORI, 5'd1, 5'd3, 16'hFFFF),
                    32'h0000_2008, 32'h0000_0000, 32'h0});
        send_insn('{i_word(OPC_LUI, 5'h1F, 5'h1F, 16'hFFFF),
                    32'h0000_200C, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_insn('{i_word(OPC_LW, 5'd1, 5'd0, 16'h8000),
                    32'h0000_2010, 32'h0000_0000, 32'hFFFF_FFFF});
        send_insn('{i_word(OPC_LW, 5'd1, 5'd31, 16'h7FFF),
                    32'h0000_2014, 32'hFFFF_FFFF, 32'h0});
        send_insn('{i_word(OPC_SW, 5'd1, 5'd2, 16'hFFFC),
                    32'h0000_2018, 32'h0000_0004, 32'hA5A5_A5A5});
        send_insn('{j_word(6'd1, 26'h3FF_FFFF), 32'h0000_201C, 32'h1, 32'h1});
        send_insn('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_insn('{r_word(5'd1, 5'd2, 5'd3, 5'd0, 6'h3F), 32'h0000_2020, 32'h5, 32'h6});
        send_insn('{r_word(5'd1, 5'd2, 5'd3, 5'd4, 6'd2), 32'h0000_2024, 32'h7, 32'h8});

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = phase_send_idle[phase];
            stall_pct     = phase_stall[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_insn(random_insn());
        end

        in_valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/msde_pkg.sv
rtl/msde_decode.sv
rtl/msde_execute.sv
rtl/msde_format.sv
rtl/mips_subset_decode_execute_core.sv
tb/sv/insn_result_checker.sv
tb/sv/tb_top.sv
